>>> hw/rtl/pixel_run_length_decoder_unit_defines.svh
// ----------------------------------------------------------------------------
// pixel run-length decoder assertion macros
// Shared concurrent assertion forms for the decoder checker.
// ----------------------------------------------------------------------------
`ifndef PIXEL_RUN_LENGTH_DECODER_UNIT_DEFINES_SVH
`define PIXEL_RUN_LENGTH_DECODER_UNIT_DEFINES_SVH

// same-cycle implication, off during reset
`define PRLD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define PRLD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/prld_pkg.sv
// ----------------------------------------------------------------------------
// prld_pkg
// Types and constants of the pixel run-length decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package prld_pkg;

   localparam int BYTE_W   = 8;
   localparam int PIXEL_W  = 32;
   localparam int GATHER_W = 24;
   localparam int COUNT_W  = 7;
   localparam int POS_W    = 2;
   localparam int PBYTES_W = 3;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 32;

   typedef logic [1:0] phase_type;

   localparam phase_type PH_HEADER  = 2'd0;
   localparam phase_type PH_REPEAT  = 2'd1;
   localparam phase_type PH_LITERAL = 2'd2;
   localparam phase_type PH_DONE    = 2'd3;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_PIXEL_BYTES  = 1'd0;
   localparam csr_index_type CSR_TOTAL_PIXELS = 1'd1;

   localparam logic [PBYTES_W-1:0] PBYTES_RESET = 3'd4;
   localparam logic [PBYTES_W-1:0] PBYTES_THREE = 3'd3;

endpackage

`default_nettype wire

>>> hw/rtl/pixel_run_length_decoder_unit.sv
// ----------------------------------------------------------------------------
// pixel_run_length_decoder_unit
// Decodes a run-length coded pixel body into (pixel, repeat count) runs.
// ----------------------------------------------------------------------------
// One compressed body byte is taken per request, at a sustained rate of one
// byte per clock while the result side is not stalled. A byte is registered
// in the input register, is decoded by a single pass of logic against the
// packet state and lands in the result register, from which a result is
// presented. The result register decouples the sides: the next byte is taken
// while a result waits, and only a full input register behind a stalled, full
// result register holds the input. A header byte carries a repeat flag in
// bit 7 and a count in bits 6..0; pixels are 3 or 4 bytes (csr register 0)
// and runs are clipped to the pixel total (csr register 1). After the result
// marked last, all further bytes are dropped until reset. Configuration must
// be written by the user only while idle; the block does not enforce this.
`default_nettype none

module pixel_run_length_decoder_unit
   import prld_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_stall,
   input  wire logic [BYTE_W-1:0]       req_byte_value,
   output      logic                    rsp_valid,
   input  wire logic                    rsp_stall,
   output      logic [PIXEL_W-1:0]      rsp_pixel_value,
   output      logic [COUNT_W-1:0]      rsp_repeat_count,
   output      logic                    rsp_last_run,
   input  wire logic                    csr_valid,
   output      logic                    csr_ready,
   input  wire csr_index_type           csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_data
);

   // configuration
   logic [PBYTES_W-1:0]  pixel_bytes_ff;
   logic [PIXEL_W-1:0]   total_pixels_ff;

   // input register
   logic                 in_valid_ff;
   logic [BYTE_W-1:0]    in_byte_ff;

   // packet state
   phase_type            phase_ff, phase_in;
   logic [COUNT_W-1:0]   run_left_ff, run_left_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [GATHER_W-1:0]  gather_ff, gather_in;
   logic [PIXEL_W-1:0]   done_ff, done_in;

   // result register
   logic                 out_valid_ff, out_valid_in;
   logic [PIXEL_W-1:0]   out_pixel_ff, out_pixel_in;
   logic [COUNT_W-1:0]   out_count_ff, out_count_in;
   logic                 out_last_ff, out_last_in;

   logic                 advance;
   logic                 accept;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign rsp_valid        = out_valid_ff;
   assign rsp_pixel_value  = out_pixel_ff;
   assign rsp_repeat_count = out_count_ff;
   assign rsp_last_run     = out_last_ff;

   always_comb begin
      logic                 blocked;
      logic [PIXEL_W-1:0]   remaining;
      logic [COUNT_W-1:0]   cnt;
      logic                 ps_three;
      logic                 complete;
      logic [PIXEL_W-1:0]   pixel;
      logic [GATHER_W-1:0]  shifted;
      logic [COUNT_W-1:0]   run_dec;
      logic [COUNT_W-1:0]   take;
      logic                 emit;
      logic [COUNT_W-1:0]   emit_count;
      logic                 emit_last;

      blocked   = (phase_ff == PH_DONE) || (done_ff >= total_pixels_ff);
      remaining = total_pixels_ff - done_ff;
      cnt       = in_byte_ff[COUNT_W-1:0];
      ps_three  = (pixel_bytes_ff == PBYTES_THREE);
      complete  = ps_three ? (pos_ff >= 2'd2) : (pos_ff == 2'd3);
      pixel     = ps_three ? {8'h00, gather_ff | {in_byte_ff, 16'h0000}}
                           : {in_byte_ff, gather_ff};
      case (pos_ff)
         2'd0:    shifted = {16'h0000, in_byte_ff};
         2'd1:    shifted = {8'h00, in_byte_ff, 8'h00};
         2'd2:    shifted = {in_byte_ff, 16'h0000};
         default: shifted = '0;
      endcase
      run_dec = run_left_ff - 7'd1;
      take    = ({25'd0, run_left_ff} < remaining) ? run_left_ff
                                                   : remaining[COUNT_W-1:0];

      phase_in    = phase_ff;
      run_left_in = run_left_ff;
      pos_in      = pos_ff;
      gather_in   = gather_ff;
      emit        = 1'b0;
      emit_count  = '0;

      if (!blocked) begin
         unique case (phase_ff) inside
            PH_HEADER: begin
               pos_in    = '0;
               gather_in = '0;
               if (in_byte_ff[BYTE_W-1]) begin
                  run_left_in = cnt;
                  phase_in    = PH_REPEAT;
               end else if (cnt != '0) begin
                  run_left_in = ({25'd0, cnt} < remaining) ? cnt
                                                           : remaining[COUNT_W-1:0];
                  phase_in    = PH_LITERAL;
               end else begin
                  run_left_in = '0;
               end
            end
            PH_REPEAT, PH_LITERAL: begin
               if (complete) begin
                  pos_in    = '0;
                  gather_in = '0;
                  if (phase_ff == PH_REPEAT) begin
                     run_left_in = '0;
                     phase_in    = PH_HEADER;
                     emit        = (take != '0);
                     emit_count  = take;
                  end else begin
                     run_left_in = run_dec;
                     if (run_dec == '0) begin
                        phase_in = PH_HEADER;
                     end
                     emit       = 1'b1;
                     emit_count = 7'd1;
                  end
               end else begin
                  gather_in = gather_ff | shifted;
                  pos_in    = pos_ff + 2'd1;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end

      // count never exceeds what is left, so equality marks the last run
      emit_last = ({25'd0, emit_count} == remaining);
      done_in   = emit ? done_ff + {25'd0, emit_count} : done_ff;
      if (emit && emit_last) begin
         phase_in = PH_DONE;
      end

      out_valid_in = in_valid_ff && emit;
      out_pixel_in = pixel;
      out_count_in = emit_count;
      out_last_in  = emit_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_bytes_ff  <= PBYTES_RESET;
         total_pixels_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PIXEL_BYTES:  pixel_bytes_ff  <= csr_data[PBYTES_W-1:0];
            CSR_TOTAL_PIXELS: total_pixels_ff <= csr_data;
            default:          pixel_bytes_ff  <= pixel_bytes_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (accept) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_byte_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         run_left_ff <= '0;
         pos_ff      <= '0;
         gather_ff   <= '0;
         done_ff     <= '0;
      end else if (advance && in_valid_ff) begin
         phase_ff    <= phase_in;
         run_left_ff <= run_left_in;
         pos_ff      <= pos_in;
         gather_ff   <= gather_in;
         done_ff     <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && out_valid_in) begin
         out_pixel_ff <= out_pixel_in;
         out_count_ff <= out_count_in;
         out_last_ff  <= out_last_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/prld_checker.sv
// ----------------------------------------------------------------------------
// prld_checker
// Port-level checks of the pixel run-length decoder, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pixel_run_length_decoder_unit_defines.svh"

module prld_checker
   import prld_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_stall,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire logic [PIXEL_W-1:0]    rsp_pixel_value,
   input wire logic [COUNT_W-1:0]    rsp_repeat_count,
   input wire logic                  rsp_last_run
);

   logic                         rsp_take;
   logic                         req_take;
   logic [PIXEL_W+COUNT_W:0]     rsp_payload;

   assign rsp_take    = rsp_valid && !rsp_stall;
   assign req_take    = req_valid && !req_stall;
   assign rsp_payload = {rsp_pixel_value, rsp_repeat_count, rsp_last_run};

   // a stalled result holds its payload
   `PRLD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_payload), "stalled result changed")

   // nothing follows the last run until reset
   `PRLD_ASSERT_NEXT(a_after_last, clock, reset, rsp_take && rsp_last_run,
      !rsp_valid, "result after the last run")

   // a fresh result goes valid on the edge after the one that took its request
   `PRLD_ASSERT_NOW(a_rsp_latency, clock, reset, $rose(rsp_valid),
      $past(req_take, 2), "result without a closing request")

   // a free result side never holds the input
   `PRLD_ASSERT_NOW(a_no_false_stall, clock, reset, !rsp_valid,
      !req_stall, "request stalled with empty result register")

endmodule

bind pixel_run_length_decoder_unit prld_checker u_prld_checker (.*);

`default_nettype wire
